// ===== sv/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// Shared opcodes and segment timing constants for the IR envelope transmitter.
// ----------------------------------------------------------------------------
package necir_pkg;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_SEND_STD = 3'd1,
      OP_SEND_EXT = 3'd2,
      OP_SEND_RAW = 3'd3,
      OP_ABORT    = 3'd4
   } opcode_type;

   // segment lengths in units T
   localparam logic [4:0] HDR_BURST      = 5'd16;
   localparam logic [4:0] BIT_BURST      = 5'd1;
   localparam logic [7:0] HDR_PERIOD     = 8'd24;
   localparam logic [7:0] RPT_PERIOD     = 8'd20;
   localparam logic [7:0] STOP_PERIOD    = 8'd72;
   localparam logic [7:0] RPT_GAP_PERIOD = 8'd172;
   localparam logic [7:0] ZERO_PERIOD    = 8'd2;
   localparam logic [7:0] ONE_PERIOD     = 8'd4;

   // data bits plus the stop segment
   localparam logic [5:0] FRAME_BITS_PLUS_ONE = 6'd33;

   localparam logic [15:0] UNIT_TICKS_RESET = 16'd1;

endpackage

// ===== sv/nec_ir_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter
// Envelope generator for NEC style IR frames driven by tick/send/abort beats.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and returns one response beat for each
// from the response register, which is loaded on acceptance. Every beat is
// handled in a single pass of compare/update logic on the timing state, so a
// tick beat may arrive every cycle; the request side only stalls when the
// response register is full and not being drained. For a tick beat, ir_level
// and busy_res show the level held during that tick; for other beats they
// show the state after the beat acted. One unit T lasts csr_unit_ticks ticks
// (zero acts as one); it may change mid-frame, and a value at or below the
// running tick count ends the unit on the next tick.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_command,
   input  logic [31:0] req_raw_code,
   input  logic        req_repeat_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ir_level,
   output logic        rsp_busy_res,
   output logic        rsp_accepted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_unit_ticks
);

   logic [15:0] unit_ticks_ff;
   logic [15:0] tick_count_ff,     tick_count_in;
   logic [7:0]  unit_position_ff,  unit_position_in;
   logic [4:0]  burst_length_ff,   burst_length_in;
   logic [7:0]  segment_length_ff, segment_length_in;
   logic [4:0]  next_burst_ff,     next_burst_in;
   logic [7:0]  next_segment_ff,   next_segment_in;
   logic [31:0] shift_code_ff,     shift_code_in;
   logic [5:0]  bits_left_ff,      bits_left_in;
   logic        repeat_enabled_ff, repeat_enabled_in;
   logic        repeat_phase_ff,   repeat_phase_in;
   logic        running_ff,        running_in;

   logic        rsp_valid_ff;
   logic        ir_level_ff,  ir_level_in;
   logic        busy_res_ff,  busy_res_in;
   logic        accepted_ff,  accepted_in;

   logic        req_fire;
   logic [15:0] limit;
   logic [15:0] tick_inc;
   logic [31:0] frame;
   logic [7:0]  addr8;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign limit    = (unit_ticks_ff == 16'd0) ? 16'd1 : unit_ticks_ff;
   assign tick_inc = tick_count_ff + 16'd1;
   assign addr8    = req_address[7:0];

   always_comb begin
      case (req_opcode)
         necir_pkg::OP_SEND_STD: frame = {~req_command, req_command, ~addr8, addr8};
         necir_pkg::OP_SEND_EXT: frame = {~req_command, req_command, req_address};
         default:                frame = req_raw_code;
      endcase
   end

   always_comb begin
      tick_count_in     = tick_count_ff;
      unit_position_in  = unit_position_ff;
      burst_length_in   = burst_length_ff;
      segment_length_in = segment_length_ff;
      next_burst_in     = next_burst_ff;
      next_segment_in   = next_segment_ff;
      shift_code_in     = shift_code_ff;
      bits_left_in      = bits_left_ff;
      repeat_enabled_in = repeat_enabled_ff;
      repeat_phase_in   = repeat_phase_ff;
      running_in        = running_ff;
      accepted_in       = 1'b0;

      case (req_opcode)
         necir_pkg::OP_TICK: begin
            if (running_ff) begin
               if (tick_inc != 16'd0 && tick_inc < limit) begin
                  tick_count_in = tick_inc;
               end else begin
                  tick_count_in    = 16'd0;
                  unit_position_in = unit_position_ff + 8'd1;
                  // end of burst: pick the following segment
                  if (unit_position_in == {3'd0, burst_length_ff}) begin
                     if (bits_left_ff != 6'd0) begin
                        bits_left_in  = bits_left_ff - 6'd1;
                        next_burst_in = necir_pkg::BIT_BURST;
                        if (bits_left_in != 6'd0) begin
                           next_segment_in = shift_code_ff[0] ? necir_pkg::ONE_PERIOD
                                                              : necir_pkg::ZERO_PERIOD;
                           shift_code_in   = {1'b0, shift_code_ff[31:1]};
                        end else begin
                           next_segment_in = necir_pkg::STOP_PERIOD;
                        end
                     end else if (repeat_enabled_ff) begin
                        repeat_phase_in = !repeat_phase_ff;
                        if (repeat_phase_in) begin
                           next_burst_in   = necir_pkg::HDR_BURST;
                           next_segment_in = necir_pkg::RPT_PERIOD;
                        end else begin
                           next_burst_in   = necir_pkg::BIT_BURST;
                           next_segment_in = necir_pkg::RPT_GAP_PERIOD;
                        end
                     end else begin
                        running_in = 1'b0;
                     end
                  end
                  if (running_in && unit_position_in >= segment_length_ff) begin
                     unit_position_in  = 8'd0;
                     burst_length_in   = next_burst_in;
                     segment_length_in = next_segment_in;
                  end
               end
            end
         end
         necir_pkg::OP_SEND_STD,
         necir_pkg::OP_SEND_EXT,
         necir_pkg::OP_SEND_RAW: begin
            if (!running_ff) begin
               tick_count_in     = 16'd0;
               unit_position_in  = 8'd0;
               burst_length_in   = necir_pkg::HDR_BURST;
               segment_length_in = necir_pkg::HDR_PERIOD;
               next_burst_in     = necir_pkg::HDR_BURST;
               next_segment_in   = necir_pkg::HDR_PERIOD;
               shift_code_in     = frame;
               bits_left_in      = necir_pkg::FRAME_BITS_PLUS_ONE;
               repeat_enabled_in = req_repeat_req;
               repeat_phase_in   = 1'b0;
               running_in        = 1'b1;
               accepted_in       = 1'b1;
            end
         end
         necir_pkg::OP_ABORT: begin
            // no further bits or repeats are picked; idles at the next burst end
            bits_left_in      = 6'd0;
            repeat_enabled_in = 1'b0;
            repeat_phase_in   = 1'b0;
         end
         default: ;
      endcase

      // going idle puts timing back to header lengths
      if (!running_in) begin
         tick_count_in     = 16'd0;
         unit_position_in  = 8'd0;
         burst_length_in   = necir_pkg::HDR_BURST;
         segment_length_in = necir_pkg::HDR_PERIOD;
         next_burst_in     = necir_pkg::HDR_BURST;
         next_segment_in   = necir_pkg::HDR_PERIOD;
         bits_left_in      = 6'd0;
         repeat_enabled_in = 1'b0;
         repeat_phase_in   = 1'b0;
      end

      if (req_opcode == necir_pkg::OP_TICK) begin
         ir_level_in = running_ff && (unit_position_ff < {3'd0, burst_length_ff});
         busy_res_in = running_ff;
      end else begin
         ir_level_in = running_in && (unit_position_in < {3'd0, burst_length_in});
         busy_res_in = running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff     <= necir_pkg::UNIT_TICKS_RESET;
         tick_count_ff     <= 16'd0;
         unit_position_ff  <= 8'd0;
         burst_length_ff   <= necir_pkg::HDR_BURST;
         segment_length_ff <= necir_pkg::HDR_PERIOD;
         next_burst_ff     <= necir_pkg::HDR_BURST;
         next_segment_ff   <= necir_pkg::HDR_PERIOD;
         shift_code_ff     <= 32'd0;
         bits_left_ff      <= 6'd0;
         repeat_enabled_ff <= 1'b0;
         repeat_phase_ff   <= 1'b0;
         running_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            unit_ticks_ff <= csr_unit_ticks;
         end
         if (req_fire) begin
            tick_count_ff     <= tick_count_in;
            unit_position_ff  <= unit_position_in;
            burst_length_ff   <= burst_length_in;
            segment_length_ff <= segment_length_in;
            next_burst_ff     <= next_burst_in;
            next_segment_ff   <= next_segment_in;
            shift_code_ff     <= shift_code_in;
            bits_left_ff      <= bits_left_in;
            repeat_enabled_ff <= repeat_enabled_in;
            repeat_phase_ff   <= repeat_phase_in;
            running_ff        <= running_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ir_level_ff <= ir_level_in;
         busy_res_ff <= busy_res_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ir_level = ir_level_ff;
   assign rsp_busy_res = busy_res_ff;
   assign rsp_accepted = accepted_ff;

endmodule

// ===== sim/nec_ir_frame_transmitter_tb.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter_tb
// Self-checking bench for the IR frame envelope transmitter. A short table of
// directed beats is followed by random tick/send/abort/reserved traffic in
// phases with different unit lengths and handshake pressure. Every request
// beat is run through a local timing predictor and each response beat is
// compared field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_tb;

   localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] OP_RESERVED_MID   = 3'd6;
   localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

   localparam int STALL_LIMIT = 2000;
   localparam int END_WAIT    = 20;
   localparam int MAX_PRINTS  = 50;
   localparam int PHASES      = 6;
   localparam int ROWS        = 12;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] address;
      logic [7:0]  command;
      logic [31:0] raw_code;
      logic        repeat_req;
   } ir_request_type;

   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic accepted;
   } ir_response_type;

   typedef struct packed {
      ir_request_type  req;
      int unsigned     beats;
      bit              fixed;
      ir_response_type resp;
   } stim_row_type;

   typedef struct packed {
      logic [15:0] unit_ticks;
      int unsigned send_idle_pct;
      int unsigned rsp_stall_pct;
      int unsigned beats;
   } phase_cfg_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [15:0] req_address;
   logic [7:0]  req_command;
   logic [31:0] req_raw_code;
   logic        req_repeat_req;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ir_level;
   logic        rsp_busy_res;
   logic        rsp_accepted;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_unit_ticks;

   // predictor state
   logic [15:0] unit_ticks_cfg;
   logic [15:0] tick_cnt;
   logic [7:0]  unit_pos;
   logic [7:0]  burst_len;
   logic [7:0]  seg_len;
   logic [7:0]  next_burst;
   logic [7:0]  next_seg;
   logic [31:0] code_sr;
   logic [5:0]  bits_rem;
   logic        rpt_en;
   logic        rpt_phase;
   logic        tx_on;

   ir_response_type expected_responses[$];
   int unsigned  error_count = 0;
   int unsigned  rsp_beats = 0;
   int unsigned  stall_cycles = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;

   // sends below are made while idle unless marked busy; the abort lands
   // inside the header burst, so the block drops out when that burst ends
   stim_row_type directed_rows [ROWS] = '{
      '{'{necir_pkg::OP_TICK, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1, 1'b1,
        '{1'b0, 1'b0, 1'b0}},
      '{'{necir_pkg::OP_ABORT, 16'h0000, 8'h00, 32'h0000_0000, 1'b1}, 1, 1'b1,
        '{1'b0, 1'b0, 1'b0}},
      '{'{OP_RESERVED_FIRST, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1}, 1, 1'b1,
        '{1'b0, 1'b0, 1'b0}},
      '{'{OP_RESERVED_LAST, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1, 1'b1,
        '{1'b0, 1'b0, 1'b0}},
      '{'{necir_pkg::OP_SEND_RAW, 16'h0000, 8'h00, 32'hFFFF_FFFF, 1'b0}, 1, 1'b1,
        '{1'b1, 1'b1, 1'b1}},
      // busy: rejected
      '{'{necir_pkg::OP_SEND_STD, 16'hFFFF, 8'hFF, 32'h0000_0000, 1'b1}, 1, 1'b1,
        '{1'b1, 1'b1, 1'b0}},
      '{'{necir_pkg::OP_SEND_RAW, 16'h0000, 8'h00, 32'h0000_0000, 1'b1}, 1, 1'b1,
        '{1'b1, 1'b1, 1'b0}},
      '{'{necir_pkg::OP_TICK, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1, 1'b1,
        '{1'b1, 1'b1, 1'b0}},
      '{'{necir_pkg::OP_ABORT, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 1, 1'b0,
        '{1'b0, 1'b0, 1'b0}},
      '{'{necir_pkg::OP_TICK, 16'h0000, 8'h00, 32'h0000_0000, 1'b0}, 15, 1'b0,
        '{1'b0, 1'b0, 1'b0}},
      '{'{necir_pkg::OP_SEND_EXT, 16'h0000, 8'hFF, 32'hFFFF_FFFF, 1'b1}, 1, 1'b0,
        '{1'b0, 1'b0, 1'b0}},
      '{'{OP_RESERVED_MID, 16'h5A5A, 8'hA5, 32'h1234_5678, 1'b0}, 1, 1'b0,
        '{1'b0, 1'b0, 1'b0}}
   };

   phase_cfg_type phase_plan [PHASES] = '{
      '{16'd2,     0,  0,  250},
      '{16'd0,     71, 0,  250},
      '{16'd1,     0,  71, 250},
      '{16'hFFFF,  20, 20, 100},
      '{16'd3,     0,  0,  150},
      '{16'd1,     20, 20, 200}
   };

   nec_ir_frame_transmitter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_command    (req_command),
      .req_raw_code   (req_raw_code),
      .req_repeat_req (req_repeat_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ir_level   (rsp_ir_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_accepted   (rsp_accepted),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_unit_ticks (csr_unit_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic frame_to_idle();
      tx_on      = 1'b0;
      tick_cnt   = '0;
      unit_pos   = '0;
      burst_len  = {3'd0, necir_pkg::HDR_BURST};
      seg_len    = necir_pkg::HDR_PERIOD;
      next_burst = {3'd0, necir_pkg::HDR_BURST};
      next_seg   = necir_pkg::HDR_PERIOD;
      bits_rem   = '0;
      rpt_en     = 1'b0;
      rpt_phase  = 1'b0;
   endtask

   // picked at the end of each burst, loaded when the current period ends
   task automatic pick_next_segment();
      if (bits_rem != 0) begin
         bits_rem   = bits_rem - 6'd1;
         next_burst = {3'd0, necir_pkg::BIT_BURST};
         if (bits_rem != 0) begin
            next_seg = code_sr[0] ? necir_pkg::ONE_PERIOD : necir_pkg::ZERO_PERIOD;
            code_sr  = code_sr >> 1;
         end else begin
            next_seg = necir_pkg::STOP_PERIOD;
         end
      end else if (rpt_en) begin
         rpt_phase = ~rpt_phase;
         if (rpt_phase) begin
            next_burst = {3'd0, necir_pkg::HDR_BURST};
            next_seg   = necir_pkg::RPT_PERIOD;
         end else begin
            next_burst = {3'd0, necir_pkg::BIT_BURST};
            next_seg   = necir_pkg::RPT_GAP_PERIOD;
         end
      end else begin
         frame_to_idle();
      end
   endtask

   task automatic advance_unit_clock();
      logic [16:0] limit;
      limit = (unit_ticks_cfg == 0) ? 17'd1 : {1'b0, unit_ticks_cfg};
      if (tx_on) begin
         tick_cnt = tick_cnt + 16'd1;
         // a lowered unit length ends the unit on the next tick
         if (tick_cnt == 0 || {1'b0, tick_cnt} >= limit) begin
            tick_cnt = '0;
            unit_pos = unit_pos + 8'd1;
            if (unit_pos == burst_len)
               pick_next_segment();
            if (tx_on && unit_pos >= seg_len) begin
               unit_pos  = '0;
               burst_len = next_burst;
               seg_len   = next_seg;
            end
         end
      end
   endtask

   task automatic predict_response(input ir_request_type r, output ir_response_type e);
      logic [31:0] frame;
      e = '0;
      if (r.opcode == necir_pkg::OP_TICK) begin
         e.ir_level = tx_on && (unit_pos < burst_len);
         e.busy_res = tx_on;
         advance_unit_clock();
      end else begin
         if (r.opcode >= necir_pkg::OP_SEND_STD && r.opcode <= necir_pkg::OP_SEND_RAW) begin
            if (!tx_on) begin
               case (r.opcode)
                  necir_pkg::OP_SEND_STD: frame = {~r.command, r.command,
                                                   ~r.address[7:0], r.address[7:0]};
                  necir_pkg::OP_SEND_EXT: frame = {~r.command, r.command, r.address};
                  default:                frame = r.raw_code;
               endcase
               frame_to_idle();
               code_sr    = frame;
               bits_rem   = necir_pkg::FRAME_BITS_PLUS_ONE;
               rpt_en     = r.repeat_req;
               tx_on      = 1'b1;
               e.accepted = 1'b1;
            end
         end else if (r.opcode == necir_pkg::OP_ABORT) begin
            bits_rem  = '0;
            rpt_en    = 1'b0;
            rpt_phase = 1'b0;
         end
         e.ir_level = tx_on && (unit_pos < burst_len);
         e.busy_res = tx_on;
      end
   endtask

   // ---------------------------------------------------------------- drivers

   function automatic ir_request_type random_request();
      ir_request_type r;
      int unsigned pick;
      pick         = $urandom_range(999);
      r.address    = 16'($urandom);
      r.command    = 8'($urandom);
      r.raw_code   = $urandom;
      r.repeat_req = 1'($urandom);
      if (pick < 930)
         r.opcode = necir_pkg::OP_TICK;
      else if (pick < 980)
         r.opcode = 3'($urandom_range(necir_pkg::OP_SEND_RAW, necir_pkg::OP_SEND_STD));
      else if (pick < 986)
         r.opcode = necir_pkg::OP_ABORT;
      else
         r.opcode = 3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
      return r;
   endfunction

   task automatic issue_request(input ir_request_type r, input bit use_fixed,
                                input ir_response_type fixed_resp);
      ir_response_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.opcode;
      req_address    <= r.address;
      req_command    <= r.command;
      req_raw_code   <= r.raw_code;
      req_repeat_req <= r.repeat_req;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_response(r, predicted);
      expected_responses.push_back(use_fixed ? fixed_resp : predicted);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_unit_ticks(input logic [15:0] value);
      csr_unit_ticks <= value;
      csr_valid      <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid      <= 1'b0;
      unit_ticks_cfg = value;
   endtask

   task automatic report_mismatch(input string what, input logic got, input logic want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("%0t: response beat %0d: %s got %b expected %b",
                  $time, rsp_beats, what, got, want);
   endtask

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      ir_response_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("rsp_valid with nothing pending", 1'b1, 1'b0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_ir_level !== want.ir_level)
               report_mismatch("ir_level", rsp_ir_level, want.ir_level);
            if (rsp_busy_res !== want.busy_res)
               report_mismatch("busy_res", rsp_busy_res, want.busy_res);
            if (rsp_accepted !== want.accepted)
               report_mismatch("accepted", rsp_accepted, want.accepted);
         end
         rsp_beats++;
      end
   end

   // no beat on any channel for too long means a hang
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("nec_ir_frame_transmitter_tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      ir_request_type  r;
      ir_response_type none;
      int unsigned     issued;
      bit              paused;
      none = '0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= necir_pkg::OP_TICK;
      req_address    <= '0;
      req_command    <= '0;
      req_raw_code   <= '0;
      req_repeat_req <= 1'b0;
      csr_valid      <= 1'b0;
      csr_unit_ticks <= necir_pkg::UNIT_TICKS_RESET;
      unit_ticks_cfg = necir_pkg::UNIT_TICKS_RESET;
      code_sr        = '0;
      frame_to_idle();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         repeat (directed_rows[i].beats)
            issue_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].resp);
      wait_for_drain();

      // unit length changes land between phases, often mid-frame
      foreach (phase_plan[p]) begin
         write_unit_ticks(phase_plan[p].unit_ticks);
         send_idle_pct = phase_plan[p].send_idle_pct;
         rsp_stall_pct = phase_plan[p].rsp_stall_pct;
         issued = 0;
         paused = 1'b0;
         while (issued < phase_plan[p].beats) begin
            r = random_request();
            issue_request(r, 1'b0, none);
            if (r.opcode <= necir_pkg::OP_ABORT)
               issued++;
            if (!paused && issued >= phase_plan[p].beats / 2) begin
               wait_for_drain();
               paused = 1'b1;
            end
         end
         wait_for_drain();
      end

      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0)
         $display("nec_ir_frame_transmitter_tb: PASS");
      else
         $display("nec_ir_frame_transmitter_tb: FAIL");
      $finish;
   end

endmodule
